/* rtl/ers_pkg.sv */
`default_nettype none
package ers_pkg;

    // Table geometry.
    localparam int MAX_EXTENTS  = 16;
    localparam int IDX_W        = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_EXTENTS + 1);
    localparam int RESULT_LIMIT = 16;
    localparam int SEG_CNT_W    = $clog2(RESULT_LIMIT + 1);
    localparam int BYTE_W       = 31;

    // Command codes.
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_MAP    = 1'b1;

    // One input item.
    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] extent_size;
        logic [BYTE_W-1:0] start_position;
        logic [BYTE_W-1:0] range_length;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [3:0]        segment_extent;
        logic [BYTE_W-1:0] segment_offset;
        logic [BYTE_W-1:0] segment_length;
        logic              last;
        logic              out_of_range;
        logic              table_full;
        logic [4:0]        extent_count;
        logic [BYTE_W-1:0] total_bytes;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic do_append;
        logic map_init;
        logic walk_step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_map;
        logic len_zero;
        logic used_zero;
        logic hit;
        logic held_v;
        logic out_free;
        logic walk_end;
    } t_dp_status;

endpackage
`default_nettype wire

/* rtl/ers_ram.sv */
`default_nettype none
module ers_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/ers_datapath.sv */
`default_nettype none
module ers_datapath import ers_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_item      i_in_data,
    input  wire t_dp_cmd    i_cmd,
    input  wire logic       i_out_ready,
    output t_dp_status      o_status,
    output logic            o_out_valid,
    output t_result         o_out_data
);

    t_item                r_item;
    logic [CNT_W-1:0]     r_used;
    logic [BYTE_W-1:0]    r_sum;
    logic [BYTE_W-1:0]    r_rel;
    logic [BYTE_W-1:0]    r_rem;
    logic [IDX_W-1:0]     r_idx;
    logic [SEG_CNT_W-1:0] r_cnt;
    t_result              r_held;
    logic                 r_held_v;
    t_result              r_out;
    logic                 r_out_v;

    logic [IDX_W-1:0]     ram_raddr;
    logic [BYTE_W-1:0]    ram_rdata;
    logic                 ram_we;

    logic [BYTE_W:0]      sum_ext;
    logic                 app_full;
    logic [32:0]          diff_a;
    logic [32:0]          diff_c;
    logic [BYTE_W-1:0]    diff_b;
    logic                 hit;
    logic [BYTE_W-1:0]    seg_len;
    logic [BYTE_W-1:0]    n_rem;
    logic                 idx_last;
    logic                 out_free;
    logic                 push;
    t_result              push_data;
    t_result              new_seg;

    // Extent size table.
    assign ram_we = i_cmd.do_append && !app_full;

    always_comb begin
        if (i_cmd.map_init) begin
            ram_raddr = '0;
        end else if (i_cmd.walk_step) begin
            ram_raddr = r_idx + IDX_W'(1);
        end else begin
            ram_raddr = r_idx;
        end
    end

    ers_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MAX_EXTENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_used[IDX_W-1:0]),
        .i_wdata (r_item.extent_size),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Append checks: table capacity and 31-bit total.
    assign sum_ext  = {1'b0, r_sum} + {1'b0, r_item.extent_size};
    assign app_full = (r_used >= CNT_W'(MAX_EXTENTS)) || sum_ext[BYTE_W];

    // Walk arithmetic. The start offset relative to the current extent base
    // never goes negative, so a hit is simply offset below extent size.
    assign diff_a = {2'b00, ram_rdata} - {2'b00, r_rel};
    assign diff_b = r_rel - ram_rdata;
    assign diff_c = {2'b00, r_rem} + {2'b00, r_rel} - {2'b00, ram_rdata};
    assign hit    = !diff_a[32] && (diff_a[31:0] != '0);

    // Clip the segment at the extent end or at the end of the range.
    always_comb begin
        if (diff_c[32]) begin
            seg_len = r_rem;
            n_rem   = '0;
        end else begin
            seg_len = diff_a[BYTE_W-1:0];
            n_rem   = diff_c[BYTE_W-1:0];
        end
    end

    assign idx_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_used);

    always_comb begin
        new_seg                = '0;
        new_seg.segment_extent = 4'(r_idx);
        new_seg.segment_offset = r_rel;
        new_seg.segment_length = seg_len;
        new_seg.extent_count   = 5'(r_used);
        new_seg.total_bytes    = r_sum;
    end

    // Results pushed into the output register.
    always_comb begin
        push      = 1'b0;
        push_data = '0;
        if (i_cmd.do_append) begin
            push                   = 1'b1;
            push_data.last         = 1'b1;
            push_data.table_full   = app_full;
            push_data.extent_count = app_full ? 5'(r_used) : 5'(r_used + CNT_W'(1));
            push_data.total_bytes  = app_full ? r_sum : sum_ext[BYTE_W-1:0];
        end else if (i_cmd.walk_step) begin
            push      = hit && r_held_v;
            push_data = r_held;
        end else if (i_cmd.finish) begin
            push = 1'b1;
            if (r_held_v) begin
                push_data = r_held;
            end else begin
                push_data.extent_count = 5'(r_used);
                push_data.total_bytes  = r_sum;
            end
            push_data.last         = 1'b1;
            push_data.out_of_range = (r_rem != '0);
        end
    end

    assign out_free = !r_out_v || i_out_ready;

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_in_data;
        end
        if (i_cmd.map_init) begin
            r_rel <= r_item.start_position;
            r_rem <= r_item.range_length;
            r_idx <= '0;
            r_cnt <= '0;
        end else if (i_cmd.walk_step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (hit) begin
                r_held <= new_seg;
                r_cnt  <= r_cnt + SEG_CNT_W'(1);
                r_rel  <= '0;
                r_rem  <= n_rem;
            end else begin
                r_rel  <= diff_b;
            end
        end
        if (push) begin
            r_out <= push_data;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_sum    <= '0;
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (ram_we) begin
                r_used <= r_used + CNT_W'(1);
                r_sum  <= sum_ext[BYTE_W-1:0];
            end
            if (i_cmd.map_init) begin
                r_held_v <= 1'b0;
            end else if (i_cmd.walk_step && hit) begin
                r_held_v <= 1'b1;
            end
            if (push) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.is_map    = (r_item.command == CMD_MAP);
        o_status.len_zero  = (r_item.range_length == '0);
        o_status.used_zero = (r_used == '0);
        o_status.hit       = hit;
        o_status.held_v    = r_held_v;
        o_status.out_free  = out_free;
        o_status.walk_end  = idx_last ||
                             (hit && ((n_rem == '0) ||
                                      (r_cnt == SEG_CNT_W'(RESULT_LIMIT - 1))));
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

/* rtl/ers_ctrl.sv */
`default_nettype none
module ers_ctrl import ers_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_dp_status i_status,
    output logic            o_in_ready,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_APPEND    = 5'b00010,
        S_MAP_START = 5'b00100,
        S_WALK      = 5'b01000,
        S_FINISH    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   stall;

    // A new segment must wait when the held one cannot move to the output.
    assign stall = i_status.hit && i_status.held_v && !i_status.out_free;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MAP_START;
                end
            end
            S_MAP_START: begin
                if (!i_status.is_map) begin
                    n_state = S_APPEND;
                end else begin
                    o_cmd.map_init = 1'b1;
                    if (i_status.len_zero || i_status.used_zero) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_APPEND: begin
                if (i_status.out_free) begin
                    o_cmd.do_append = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = !stall;
                if (!stall && i_status.walk_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* rtl/extent_range_splitter_unit.sv */
`default_nettype none
// Extent range splitter. Append commands add extent sizes to a table of up to
// MAX_EXTENTS entries laid end to end in one byte space; map commands split a
// byte range into per-extent segments. One item is handled at a time. The
// walk of a map reads one table entry per cycle, unless a stall holds it,
// from the single read port of the extent RAM. The walk stops early once the
// range is used up or RESULT_LIMIT segments are found, and an empty range or
// an empty table skips it. The next input transfer can happen in the same
// cycle that the final result is presented. A result that waits at the
// output holds a map walk only when a further segment is found, and holds an
// append or the final map result until the output register frees; the next
// item is taken while the last result still waits.
module extent_range_splitter_unit import ers_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_item   i_in_data,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_result      o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer.
    ers_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Table, walk arithmetic and output register.
    ers_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

/* rtl/ers_checker.sv */
`default_nettype none
module ers_checker import ers_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_in_valid,
    input wire logic    o_in_ready,
    input wire logic    o_out_valid,
    input wire logic    i_out_ready,
    input wire t_result o_out_data
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // One item at a time: no transfer in the cycle after one.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after a transfer");

    // Only a final result may carry flags, and a non-final one has a nonzero length.
    a_mid_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |->
            !o_out_data.table_full && !o_out_data.out_of_range &&
            (o_out_data.segment_length != '0))
        else $error("flag on a non-final result");

    // A rejected append is a single empty result.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.table_full |->
            o_out_data.last && !o_out_data.out_of_range &&
            (o_out_data.segment_length == '0))
        else $error("malformed rejected append");

endmodule

bind extent_range_splitter_unit ers_checker u_ers_checker (.*);
`default_nettype wire
